>>> hw/rtl/mi4_pkg.sv
// shared constants, types and index helpers for the 4x4 matrix inverse
package mi4_pkg;

    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int NCH     = 4;
    localparam int CHUNK_W = $clog2(NCH);
    localparam int XW      = NCH * ELEM_WIDTH;
    localparam int ADJ_W   = 3 * ELEM_WIDTH + 4;
    localparam int ACC_W   = 4 * ELEM_WIDTH + 8;
    localparam int MUL_W   = 2 * (ELEM_WIDTH + 1);
    localparam int QB      = ELEM_WIDTH + 1;
    localparam int RW      = ACC_W + QB + 1;
    localparam int CNT_W   = $clog2(QB + 1);

    localparam logic [QB:0] MAG_MAXP = (QB + 1)'((64'd1 << (ELEM_WIDTH - 1)) - 64'd1);
    localparam logic [QB:0] MAG_MINN = (QB + 1)'(64'd1 << (ELEM_WIDTH - 1));

    localparam logic [3:0]         LOAD_LAST  = 4'd15;
    localparam logic [3:0]         ENT_LAST   = 4'd15;
    localparam logic [3:0]         COF_LAST   = 4'd15;
    localparam logic [2:0]         TERM_LAST  = 3'd5;
    localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(NCH - 1);

    typedef enum logic [1:0] {MD_PROD, MD_COF, MD_DET} mac_dest_t;

    typedef enum logic [3:0] {
        ST_LOAD, ST_TA, ST_TB, ST_TC, ST_MUL, ST_DRAIN, ST_TD, ST_COF,
        ST_DETA, ST_NEXT, ST_CHK, ST_SING, ST_DRD, ST_DLD, ST_DWAIT, ST_DOUT
    } top_state_t;

    typedef enum logic [1:0] {DV_IDLE, DV_ITER, DV_ROUND} div_state_t;

    typedef struct packed {
        logic                  done;
        logic                  sat;
        logic [ELEM_WIDTH-1:0] value;
    } div_res_t;

    // column of minor row i used by term k of the 3x3 expansion
    function automatic logic [1:0] perm_col(logic [2:0] k, logic [1:0] i);
        logic [5:0] cols;
        unique case (k)
            3'd0:    cols = {2'd2, 2'd1, 2'd0};
            3'd1:    cols = {2'd0, 2'd2, 2'd1};
            3'd2:    cols = {2'd1, 2'd0, 2'd2};
            3'd3:    cols = {2'd1, 2'd2, 2'd0};
            3'd4:    cols = {2'd0, 2'd1, 2'd2};
            3'd5:    cols = {2'd2, 2'd0, 2'd1};
            default: cols = {2'd2, 2'd1, 2'd0};
        endcase
        return cols[i*2 +: 2];
    endfunction

    function automatic logic perm_neg(logic [2:0] k);
        return (k >= 3'd3);
    endfunction

    // matrix address of element (i, perm) of the minor that drops row q, column p
    function automatic logic [3:0] minor_addr(logic [1:0] q, logic [1:0] p,
                                              logic [1:0] i, logic [2:0] k);
        logic [1:0] j;
        logic [1:0] row;
        logic [1:0] col;
        j   = perm_col(k, i);
        row = (i >= q) ? i + 2'd1 : i;
        col = (j >= p) ? j + 2'd1 : j;
        return {row, col};
    endfunction

endpackage

>>> hw/rtl/mi4_div.sv
// restoring divider: rounded, saturated quotient of one adjugate entry by the determinant
module mi4_div import mi4_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [ADJ_W-1:0] num,
    input  logic [ACC_W-1:0] den_mag,
    input  logic             den_neg,
    output div_res_t         res
);

    div_state_t            dstate_reg, dstate_next;
    logic [RW-1:0]         r_reg;
    logic [RW-1:0]         dsh_reg;
    logic [QB-1:0]         q_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  ovf_reg;
    logic                  neg_reg;
    logic                  done_reg;
    logic                  sat_reg;
    logic [ELEM_WIDTH-1:0] value_reg;

    logic                  num_neg;
    logic [ADJ_W-1:0]      num_mag;
    logic                  ge;
    logic                  round_up;
    logic [QB:0]           q_rnd;
    logic [QB:0]           q_neg;
    logic                  sat_c;
    logic [ELEM_WIDTH-1:0] value_c;

    assign num_neg  = num[ADJ_W-1];
    assign num_mag  = num_neg ? (~num + 1'b1) : num;
    assign ge       = (r_reg >= dsh_reg);
    assign round_up = ({r_reg, 1'b0} >= (RW + 1)'(den_mag));
    assign q_rnd    = {1'b0, q_reg} + (QB + 1)'(round_up);
    assign q_neg    = ~q_rnd + 1'b1;

    always_comb begin
        if (neg_reg) begin
            sat_c   = ovf_reg || (q_rnd > MAG_MINN);
            value_c = sat_c ? {1'b1, {(ELEM_WIDTH-1){1'b0}}} : q_neg[ELEM_WIDTH-1:0];
        end else begin
            sat_c   = ovf_reg || (q_rnd > MAG_MAXP);
            value_c = sat_c ? {1'b0, {(ELEM_WIDTH-1){1'b1}}} : q_rnd[ELEM_WIDTH-1:0];
        end
    end

    always_comb begin
        dstate_next = dstate_reg;
        unique case (dstate_reg)
            DV_IDLE:  if (start) dstate_next = DV_ITER;
            DV_ITER:  if (cnt_reg == '0) dstate_next = DV_ROUND;
            DV_ROUND: dstate_next = DV_IDLE;
            default:  dstate_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dstate_reg <= DV_IDLE;
            done_reg   <= 1'b0;
        end else begin
            dstate_reg <= dstate_next;
            if (start) begin
                done_reg <= 1'b0;
            end else if (dstate_reg == DV_ROUND) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            r_reg   <= RW'(num_mag) << (2 * FRAC_BITS);
            dsh_reg <= RW'(den_mag) << QB;
            q_reg   <= '0;
            cnt_reg <= CNT_W'(QB);
            ovf_reg <= 1'b0;
            neg_reg <= num_neg ^ den_neg;
        end else if (dstate_reg == DV_ITER) begin
            // top step only tests whether the quotient overflows the window
            if (cnt_reg == CNT_W'(QB)) begin
                ovf_reg <= ge;
            end else begin
                if (ge) r_reg <= r_reg - dsh_reg;
                q_reg <= {q_reg[QB-2:0], ge};
            end
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (dstate_reg == DV_ROUND) begin
            sat_reg   <= sat_c;
            value_reg <= value_c;
        end
    end

    assign res.done  = done_reg;
    assign res.sat   = sat_reg;
    assign res.value = value_reg;

endmodule

>>> hw/rtl/matrix_inverse_4x4.sv
// 4x4 matrix inverse by adjugate over determinant, exact wide fixed point
// throughput: 16 element items per matrix, one per cycle while loading
// sequence: cofactors and determinant first (6 terms per cofactor on one 33x33
//   multiplier and the one-port matrix ram), then one result at a time in the
//   serial divider
// reset: synchronous active-low aresetn clears control; rams are not cleared
module matrix_inverse_4x4 import mi4_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ELEM_WIDTH-1:0] s_elem_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ELEM_WIDTH-1:0] m_out_value,
    output logic [1:0]            m_out_row,
    output logic [1:0]            m_out_col,
    output logic                  m_singular,
    output logic                  m_saturated,
    output logic                  m_last_out
);

    logic [ELEM_WIDTH-1:0] mat_mem [16];
    logic [ADJ_W-1:0]      adj_mem [16];
    logic [ELEM_WIDTH-1:0] mat_rdata_reg;
    logic [ADJ_W-1:0]      adj_rdata_reg;

    top_state_t            state_reg, state_next;
    logic [3:0]            load_count_reg, load_count_next;
    logic [1:0]            cq_reg, cq_next;
    logic [1:0]            cp_reg, cp_next;
    logic [2:0]            term_reg, term_next;
    logic [CHUNK_W-1:0]    chunk_reg, chunk_next;
    mac_dest_t             dest_reg, dest_next;
    logic [XW-1:0]         x_reg, x_next;
    logic [ELEM_WIDTH:0]   e_reg, e_next;
    logic [3:0]            ent_reg, ent_next;
    logic [ACC_W-1:0]      dmag_reg, dmag_next;
    logic                  dneg_reg, dneg_next;

    logic                  m_valid_reg;
    logic [ELEM_WIDTH-1:0] out_value_reg;
    logic [1:0]            out_row_reg;
    logic [1:0]            out_col_reg;
    logic                  sing_reg;
    logic                  sat_reg;
    logic                  last_reg;

    logic [MUL_W-1:0]      mul_reg;
    logic [CHUNK_W-1:0]    mul_sh_reg;
    mac_dest_t             mul_dest_reg;
    logic                  mul_vld_reg;
    logic [ACC_W-1:0]      p_acc_reg;
    logic [ACC_W-1:0]      cof_acc_reg;
    logic [ACC_W-1:0]      det_acc_reg;

    logic                  s_accept;
    logic                  out_free;
    logic                  mat_rd_en;
    logic [3:0]            mat_rd_addr;
    logic                  adj_we;
    logic                  adj_re;
    logic [3:0]            adj_rd_addr;
    logic                  pacc_clr, cof_clr, det_clr;
    logic                  mac_issue;
    logic                  div_start;
    logic                  out_load_div, out_load_sing;
    logic                  sign_neg;
    logic [ELEM_WIDTH:0]   rd_ext;
    logic [ELEM_WIDTH:0]   chunk_op;
    logic [MUL_W-1:0]      mul_c;
    logic [ACC_W-1:0]      addend;
    div_res_t              div_res;

    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign sign_neg = perm_neg(term_reg) ^ cq_reg[0] ^ cp_reg[0];
    assign rd_ext   = {mat_rdata_reg[ELEM_WIDTH-1], mat_rdata_reg};

    // chunk of the multiplicand: lower chunks unsigned, top chunk signed
    assign chunk_op = (chunk_reg == CHUNK_LAST)
                    ? {x_reg[XW-1], x_reg[chunk_reg*ELEM_WIDTH +: ELEM_WIDTH]}
                    : {1'b0, x_reg[chunk_reg*ELEM_WIDTH +: ELEM_WIDTH]};
    assign mul_c    = MUL_W'($signed(chunk_op) * $signed(e_reg));
    assign addend   = {{(ACC_W-MUL_W){mul_reg[MUL_W-1]}}, mul_reg}
                      << (mul_sh_reg * ELEM_WIDTH);

    always_comb begin
        state_next      = state_reg;
        load_count_next = s_accept ? load_count_reg + 4'd1 : load_count_reg;
        cq_next         = cq_reg;
        cp_next         = cp_reg;
        term_next       = term_reg;
        chunk_next      = chunk_reg;
        dest_next       = dest_reg;
        x_next          = x_reg;
        e_next          = e_reg;
        ent_next        = ent_reg;
        dmag_next       = dmag_reg;
        dneg_next       = dneg_reg;
        s_ready         = 1'b0;
        mat_rd_en       = 1'b0;
        mat_rd_addr     = minor_addr(cq_reg, cp_reg, 2'd0, term_reg);
        adj_we          = 1'b0;
        adj_re          = 1'b0;
        adj_rd_addr     = ent_reg;
        pacc_clr        = 1'b0;
        cof_clr         = 1'b0;
        det_clr         = 1'b0;
        mac_issue       = 1'b0;
        div_start       = 1'b0;
        out_load_div    = 1'b0;
        out_load_sing   = 1'b0;

        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_accept && load_count_reg == LOAD_LAST) begin
                    cq_next    = 2'd0;
                    cp_next    = 2'd0;
                    term_next  = 3'd0;
                    det_clr    = 1'b1;
                    state_next = ST_TA;
                end
            end
            ST_TA: begin
                mat_rd_en  = 1'b1;
                if (term_reg == 3'd0) cof_clr = 1'b1;
                state_next = ST_TB;
            end
            ST_TB: begin
                x_next      = {{(XW-ELEM_WIDTH){mat_rdata_reg[ELEM_WIDTH-1]}}, mat_rdata_reg};
                mat_rd_en   = 1'b1;
                mat_rd_addr = minor_addr(cq_reg, cp_reg, 2'd1, term_reg);
                state_next  = ST_TC;
            end
            ST_TC: begin
                e_next     = rd_ext;
                pacc_clr   = 1'b1;
                dest_next  = MD_PROD;
                chunk_next = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                mac_issue  = 1'b1;
                chunk_next = chunk_reg + 1'b1;
                if (chunk_reg == CHUNK_LAST) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                // last partial product lands in its accumulator this cycle
                unique case (dest_reg)
                    MD_PROD: begin
                        mat_rd_en   = 1'b1;
                        mat_rd_addr = minor_addr(cq_reg, cp_reg, 2'd2, term_reg);
                        state_next  = ST_TD;
                    end
                    MD_COF: begin
                        if (term_reg == TERM_LAST) begin
                            state_next = ST_COF;
                        end else begin
                            term_next  = term_reg + 3'd1;
                            state_next = ST_TA;
                        end
                    end
                    MD_DET:  state_next = ST_NEXT;
                    default: state_next = ST_NEXT;
                endcase
            end
            ST_TD: begin
                x_next     = p_acc_reg[XW-1:0];
                e_next     = sign_neg ? (~rd_ext + 1'b1) : rd_ext;
                dest_next  = MD_COF;
                chunk_next = '0;
                state_next = ST_MUL;
            end
            ST_COF: begin
                adj_we = 1'b1;
                if (cq_reg == 2'd0) begin
                    mat_rd_en   = 1'b1;
                    mat_rd_addr = {2'd0, cp_reg};
                    state_next  = ST_DETA;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_DETA: begin
                x_next     = cof_acc_reg[XW-1:0];
                e_next     = rd_ext;
                dest_next  = MD_DET;
                chunk_next = '0;
                state_next = ST_MUL;
            end
            ST_NEXT: begin
                term_next = 3'd0;
                if ({cq_reg, cp_reg} == COF_LAST) begin
                    state_next = ST_CHK;
                end else begin
                    {cq_next, cp_next} = {cq_reg, cp_reg} + 4'd1;
                    state_next = ST_TA;
                end
            end
            ST_CHK: begin
                dneg_next = det_acc_reg[ACC_W-1];
                dmag_next = det_acc_reg[ACC_W-1] ? (~det_acc_reg + 1'b1) : det_acc_reg;
                ent_next  = 4'd0;
                if (det_acc_reg == '0) state_next = ST_SING;
                else                   state_next = ST_DRD;
            end
            ST_SING: begin
                s_ready = (load_count_reg != LOAD_LAST);
                if (out_free) begin
                    out_load_sing = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            ST_DRD: begin
                s_ready    = (load_count_reg != LOAD_LAST);
                adj_re     = 1'b1;
                state_next = ST_DLD;
            end
            ST_DLD: begin
                s_ready    = (load_count_reg != LOAD_LAST);
                div_start  = 1'b1;
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                s_ready = (load_count_reg != LOAD_LAST);
                if (div_res.done) state_next = ST_DOUT;
            end
            ST_DOUT: begin
                s_ready = (load_count_reg != LOAD_LAST);
                if (out_free) begin
                    out_load_div = 1'b1;
                    if (ent_reg == ENT_LAST) begin
                        state_next = ST_LOAD;
                    end else begin
                        ent_next   = ent_reg + 4'd1;
                        state_next = ST_DRD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            load_count_reg <= 4'd0;
            m_valid_reg    <= 1'b0;
            mul_vld_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            mul_vld_reg    <= mac_issue;
            if (out_load_div || out_load_sing) m_valid_reg <= 1'b1;
            else if (m_ready)                  m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        cq_reg    <= cq_next;
        cp_reg    <= cp_next;
        term_reg  <= term_next;
        chunk_reg <= chunk_next;
        dest_reg  <= dest_next;
        x_reg     <= x_next;
        e_reg     <= e_next;
        ent_reg   <= ent_next;
        dmag_reg  <= dmag_next;
        dneg_reg  <= dneg_next;
        if (mac_issue) begin
            mul_reg      <= mul_c;
            mul_sh_reg   <= chunk_reg;
            mul_dest_reg <= dest_reg;
        end
        if (out_load_sing) begin
            out_value_reg <= '0;
            out_row_reg   <= 2'd0;
            out_col_reg   <= 2'd0;
            sing_reg      <= 1'b1;
            sat_reg       <= 1'b0;
            last_reg      <= 1'b1;
        end else if (out_load_div) begin
            out_value_reg <= div_res.value;
            out_row_reg   <= ent_reg[3:2];
            out_col_reg   <= ent_reg[1:0];
            sing_reg      <= 1'b0;
            sat_reg       <= div_res.sat;
            last_reg      <= (ent_reg == ENT_LAST);
        end
    end

    // accumulators, modulo 2^ACC_W; final values always fit
    always_ff @(posedge aclk) begin
        if (pacc_clr) begin
            p_acc_reg <= '0;
        end else if (mul_vld_reg && mul_dest_reg == MD_PROD) begin
            p_acc_reg <= p_acc_reg + addend;
        end
        if (cof_clr) begin
            cof_acc_reg <= '0;
        end else if (mul_vld_reg && mul_dest_reg == MD_COF) begin
            cof_acc_reg <= cof_acc_reg + addend;
        end
        if (det_clr) begin
            det_acc_reg <= '0;
        end else if (mul_vld_reg && mul_dest_reg == MD_DET) begin
            det_acc_reg <= det_acc_reg + addend;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) mat_mem[load_count_reg] <= s_elem_value;
        if (mat_rd_en) mat_rdata_reg <= mat_mem[mat_rd_addr];
    end

    // adjugate stored transposed: cofactor (q,p) goes to entry (p,q)
    always_ff @(posedge aclk) begin
        if (adj_we) adj_mem[{cp_reg, cq_reg}] <= cof_acc_reg[ADJ_W-1:0];
        if (adj_re) adj_rdata_reg <= adj_mem[adj_rd_addr];
    end

    mi4_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (adj_rdata_reg),
        .den_mag (dmag_reg),
        .den_neg (dneg_reg),
        .res     (div_res)
    );

    assign m_valid     = m_valid_reg;
    assign m_out_value = out_value_reg;
    assign m_out_row   = out_row_reg;
    assign m_out_col   = out_col_reg;
    assign m_singular  = sing_reg;
    assign m_saturated = sat_reg;
    assign m_last_out  = last_reg;

endmodule

>>> hw/rtl/mi4_checker.sv
// port-level assertions for the matrix inverse, bound to the top level
module mi4_checker import mi4_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [ELEM_WIDTH-1:0] m_out_value,
    input logic [1:0]            m_out_row,
    input logic [1:0]            m_out_col,
    input logic                  m_singular,
    input logic                  m_saturated,
    input logic                  m_last_out
);

    localparam logic [ELEM_WIDTH-1:0] VAL_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic [ELEM_WIDTH-1:0] VAL_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_value) && $stable(m_last_out))
        else $error("result item changed while stalled");

    a_sing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> m_last_out && !m_saturated && m_out_value == '0
                                  && m_out_row == 2'd0 && m_out_col == 2'd0)
        else $error("singular item malformed");

    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> (m_out_value == VAL_MAX || m_out_value == VAL_MIN))
        else $error("saturated item not at a bound");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_singular |-> (m_last_out == (m_out_row == 2'd3 && m_out_col == 2'd3)))
        else $error("last flag not on final entry");

endmodule

bind matrix_inverse_4x4 mi4_checker u_mi4_checker (.*);
